// ----- design/masked_sprite_blit_scan_defines.svh -----
// Assertion macros shared by the masked sprite blit scanner checkers.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef MASKED_SPRITE_BLIT_SCAN_DEFINES_SVH
`define MASKED_SPRITE_BLIT_SCAN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MSBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MSBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/msbs_pkg.sv -----
// Types, constants and helpers of the masked sprite blit scanner.
// Used by every module of the block; depends on nothing.
`default_nettype none

package msbs_pkg;

    localparam int ROW_BYTES_DEF  = 1024;
    localparam int MAX_SIDE_DEF   = 8;
    localparam int MASK_CELLS_DEF = 64;

    localparam int CELL_IDX_W = 6;

    typedef enum logic {
        KIND_DRAW = 1'b0,
        KIND_LOAD = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        REG_FRAME_SRC_X  = 3'd0,
        REG_FRAME_SRC_Y  = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_HEIGHT = 3'd3,
        REG_ANCHOR_X     = 3'd4,
        REG_ANCHOR_Y     = 3'd5,
        REG_SHIFT_X      = 3'd6,
        REG_SHIFT_Y      = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } scan_state_t;

    typedef struct packed {
        logic        [7:0] frame_src_x;
        logic        [7:0] frame_src_y;
        logic        [3:0] frame_width;
        logic        [3:0] frame_height;
        logic signed [7:0] anchor_x;
        logic signed [7:0] anchor_y;
        logic signed [7:0] shift_x;
        logic signed [7:0] shift_y;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic               flip_frame;
        logic               flip_extra;
        logic               draw_masked;
        logic signed [7:0]  mask_origin_x;
        logic signed [7:0]  mask_origin_y;
        logic        [3:0]  mask_cols;
        logic        [3:0]  mask_rows;
    } draw_cmd_t;

    typedef struct packed {
        logic                  en;
        logic [CELL_IDX_W-1:0] addr;
        logic                  data;
    } mask_wr_t;

    typedef struct packed {
        logic                  en;
        logic [CELL_IDX_W-1:0] addr;
    } mask_rd_t;

    typedef struct packed {
        logic signed [12:0] dest_x;
        logic signed [12:0] dest_y;
        logic        [17:0] source_offset;
        logic               write_pixel;
        logic               last;
    } pix_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ----- design/msbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on msbs_pkg for the address width helper.
`default_nettype none

module msbs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = msbs_pkg::MASK_CELLS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [msbs_pkg::addr_w(DEPTH)-1:0]    waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [msbs_pkg::addr_w(DEPTH)-1:0]    raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/msbs_mask.sv -----
// Mask cell store: one-bit RAM plus per-cell written flags, unwritten cells read 0.
// Depends on msbs_pkg and msbs_ram.
`default_nettype none

module msbs_mask #(
    parameter int MASK_CELLS = msbs_pkg::MASK_CELLS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire msbs_pkg::mask_wr_t wr,
    input  wire msbs_pkg::mask_rd_t rd,
    output logic                    rd_data
);

    localparam int AW = msbs_pkg::addr_w(MASK_CELLS);

    logic [MASK_CELLS-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic                  ram_q;
    logic                  wr_ok;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;

    assign wr_ok = wr.en && ({1'b0, wr.addr} < 7'(MASK_CELLS));
    assign waddr = wr.addr[AW-1:0];
    assign raddr = rd.addr[AW-1:0];

    msbs_ram #(
        .WIDTH (1),
        .DEPTH (MASK_CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rd_data = rd_valid_reg & ram_q;

endmodule

`default_nettype wire

// ----- design/msbs_scan.sv -----
// Pixel scan sequencer: walks the frame, issues mask reads, builds results.
// Depends on msbs_pkg; mask read data is registered and arrives in the cycle after the request.
`default_nettype none

module msbs_scan #(
    parameter int ROW_BYTES  = msbs_pkg::ROW_BYTES_DEF,
    parameter int MAX_SIDE   = msbs_pkg::MAX_SIDE_DEF,
    parameter int MASK_CELLS = msbs_pkg::MASK_CELLS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire msbs_pkg::cfg_t      cfg,
    input  wire msbs_pkg::draw_cmd_t cmd,
    output logic                     busy,
    output msbs_pkg::mask_rd_t       mask_rd,
    input  wire logic                mask_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output msbs_pkg::pix_t           out_pix
);

    msbs_pkg::scan_state_t state_reg, state_next;

    logic [3:0]  lx_reg, ly_reg;
    logic [3:0]  w_reg, h_reg, mcols_reg, mrows_reg;
    logic        flip_reg, want_reg;
    logic [11:0] mx0_reg, my0_reg;
    logic [12:0] dx0_reg, dy0_reg;

    logic           s2_valid_reg, s2_in_store_reg, s2_want_reg;
    msbs_pkg::pix_t s2_pix_reg, s2_pix_next;
    logic           out_valid_reg;
    msbs_pkg::pix_t out_pix_reg, out_pix_next;

    logic              adv, issue, row_end, at_end, empty, flip_in;
    logic [3:0]        w_cl, h_cl, slx;
    logic signed [9:0] ax10, eff_ax, rel_x0, rel_y0;
    logic [11:0]       mx, my;
    logic              in_mask, in_store;
    logic [7:0]        ci;
    logic [8:0]        col_sum;
    logic [17:0]       row_off, col_off;

    // start-of-draw setup
    always_comb
    begin
        w_cl    = (cfg.frame_width > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : cfg.frame_width;
        h_cl    = (cfg.frame_height > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : cfg.frame_height;
        empty   = (w_cl == 4'd0) || (h_cl == 4'd0);
        flip_in = cmd.flip_frame ^ cmd.flip_extra;
        ax10    = 10'(cfg.anchor_x);
        eff_ax  = flip_in ? (signed'(10'(w_cl)) - ax10) : ax10;
        rel_x0  = 10'(cfg.shift_x) - eff_ax;
        rel_y0  = 10'(cfg.shift_y) - 10'(cfg.anchor_y);
    end

    assign adv     = !out_valid_reg || out_ready;
    assign row_end = (lx_reg == w_reg - 4'd1);
    assign at_end  = row_end && (ly_reg == h_reg - 4'd1);

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            msbs_pkg::SCAN_IDLE:
            begin
                if (start && !empty)
                begin
                    state_next = msbs_pkg::SCAN_RUN;
                end
            end
            msbs_pkg::SCAN_RUN:
            begin
                busy = 1'b1;
                if (adv)
                begin
                    issue = 1'b1;
                    if (at_end)
                    begin
                        state_next = msbs_pkg::SCAN_IDLE;
                    end
                end
            end
        endcase
    end

    // per-pixel address and result generation
    always_comb
    begin
        mx       = mx0_reg + 12'(lx_reg);
        my       = my0_reg + 12'(ly_reg);
        in_mask  = !mx[11] && !my[11] && (mx < 12'(mcols_reg)) && (my < 12'(mrows_reg));
        ci       = 8'({4'd0, my[3:0]} * {4'd0, mcols_reg}) + {4'd0, mx[3:0]};
        in_store = in_mask && (9'(ci) < 9'(MASK_CELLS));
        slx      = flip_reg ? (w_reg - 4'd1 - lx_reg) : lx_reg;
        row_off  = 18'((10'(cfg.frame_src_y) + 10'(ly_reg)) * ROW_BYTES);
        col_sum  = 9'(cfg.frame_src_x) + 9'(slx);
        col_off  = {7'd0, col_sum, 2'b00};

        s2_pix_next               = '0;
        s2_pix_next.dest_x        = dx0_reg + 13'(lx_reg);
        s2_pix_next.dest_y        = dy0_reg + 13'(ly_reg);
        s2_pix_next.source_offset = row_off + col_off;
        s2_pix_next.last          = at_end;

        mask_rd.en   = issue && in_store;
        mask_rd.addr = ci[msbs_pkg::CELL_IDX_W-1:0];

        out_pix_next             = s2_pix_reg;
        out_pix_next.write_pixel = ((s2_in_store_reg & mask_data) == s2_want_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msbs_pkg::SCAN_IDLE;
            lx_reg        <= 4'd0;
            ly_reg        <= 4'd0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                lx_reg <= 4'd0;
                ly_reg <= 4'd0;
            end
            else if (issue)
            begin
                if (row_end)
                begin
                    lx_reg <= 4'd0;
                    ly_reg <= ly_reg + 4'd1;
                end
                else
                begin
                    lx_reg <= lx_reg + 4'd1;
                end
            end
            if (adv)
            begin
                out_valid_reg <= s2_valid_reg;
                s2_valid_reg  <= issue;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg     <= w_cl;
            h_reg     <= h_cl;
            flip_reg  <= flip_in;
            want_reg  <= cmd.draw_masked;
            mcols_reg <= cmd.mask_cols;
            mrows_reg <= cmd.mask_rows;
            mx0_reg   <= 12'(rel_x0) - 12'(cmd.mask_origin_x);
            my0_reg   <= 12'(rel_y0) - 12'(cmd.mask_origin_y);
            dx0_reg   <= 13'(cmd.pos_x) + 13'(rel_x0);
            dy0_reg   <= 13'(cmd.pos_y) + 13'(rel_y0);
        end
        if (adv)
        begin
            s2_pix_reg      <= s2_pix_next;
            s2_in_store_reg <= in_store;
            s2_want_reg     <= want_reg;
            out_pix_reg     <= out_pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

endmodule

`default_nettype wire

// ----- design/masked_sprite_blit_scan.sv -----
// Masked sprite blit scanner top level: config registers, mask store, pixel scan.
// A draw transfer yields its first result through the scan state, s2 and output registers,
// then one result per cycle (w*h results, bounded by the output handshake); the next item
// is taken the cycle after the last pixel is issued. A mask load yields no result.
// Throughput is set by the single mask read port: one pixel per cycle while the output is not stalled.
// Reset clears config to defaults and all mask cells to zero at once, no clearing pass.
`default_nettype none

module masked_sprite_blit_scan #(
    parameter int ROW_BYTES  = msbs_pkg::ROW_BYTES_DEF,
    parameter int MAX_SIDE   = msbs_pkg::MAX_SIDE_DEF,
    parameter int MASK_CELLS = msbs_pkg::MASK_CELLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, flip_frame, flip_extra, draw_masked, mask_origin_x,
    // mask_origin_y, mask_cols, mask_rows, cell_index, cell_value, zero pad
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // dest_x, dest_y, source_offset, zero pad
    output logic             m_tuser,   // write_pixel
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    msbs_pkg::cfg_t      cfg_reg;
    msbs_pkg::draw_cmd_t cmd;
    msbs_pkg::mask_wr_t  mask_wr;
    msbs_pkg::mask_rd_t  mask_rd;
    msbs_pkg::pix_t      pix;
    logic                mask_data;
    logic                busy;
    logic                in_xfer;
    logic                start;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign in_xfer   = s_tvalid && s_tready;
    assign start     = in_xfer && (msbs_pkg::item_kind_t'(s_tuser) == msbs_pkg::KIND_DRAW);

    always_comb
    begin
        cmd.pos_x         = s_tdata[11:0];
        cmd.pos_y         = s_tdata[23:12];
        cmd.flip_frame    = s_tdata[24];
        cmd.flip_extra    = s_tdata[25];
        cmd.draw_masked   = s_tdata[26];
        cmd.mask_origin_x = s_tdata[34:27];
        cmd.mask_origin_y = s_tdata[42:35];
        cmd.mask_cols     = s_tdata[46:43];
        cmd.mask_rows     = s_tdata[50:47];

        mask_wr.en   = in_xfer && (msbs_pkg::item_kind_t'(s_tuser) == msbs_pkg::KIND_LOAD);
        mask_wr.addr = s_tdata[56:51];
        mask_wr.data = s_tdata[57];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_src_x  <= 8'd0;
            cfg_reg.frame_src_y  <= 8'd0;
            cfg_reg.frame_width  <= 4'd8;
            cfg_reg.frame_height <= 4'd8;
            cfg_reg.anchor_x     <= 8'sd0;
            cfg_reg.anchor_y     <= 8'sd0;
            cfg_reg.shift_x      <= 8'sd0;
            cfg_reg.shift_y      <= 8'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (msbs_pkg::cfg_reg_t'(cfg_index))
                msbs_pkg::REG_FRAME_SRC_X:  cfg_reg.frame_src_x  <= cfg_data;
                msbs_pkg::REG_FRAME_SRC_Y:  cfg_reg.frame_src_y  <= cfg_data;
                msbs_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[3:0];
                msbs_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[3:0];
                msbs_pkg::REG_ANCHOR_X:     cfg_reg.anchor_x     <= cfg_data;
                msbs_pkg::REG_ANCHOR_Y:     cfg_reg.anchor_y     <= cfg_data;
                msbs_pkg::REG_SHIFT_X:      cfg_reg.shift_x      <= cfg_data;
                msbs_pkg::REG_SHIFT_Y:      cfg_reg.shift_y      <= cfg_data;
            endcase
        end
    end

    msbs_mask #(
        .MASK_CELLS (MASK_CELLS)
    ) u_mask (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mask_wr),
        .rd      (mask_rd),
        .rd_data (mask_data)
    );

    msbs_scan #(
        .ROW_BYTES  (ROW_BYTES),
        .MAX_SIDE   (MAX_SIDE),
        .MASK_CELLS (MASK_CELLS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .busy      (busy),
        .mask_rd   (mask_rd),
        .mask_data (mask_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (pix)
    );

    assign m_tdata = {4'd0, pix.source_offset, pix.dest_y, pix.dest_x};
    assign m_tuser = pix.write_pixel;
    assign m_tlast = pix.last;

endmodule

`default_nettype wire

// ----- design/msbs_checker.sv -----
// Port-level checks of the masked sprite blit scanner, bound to the top level.
// Depends on masked_sprite_blit_scan_defines.svh for the assertion macros.
`default_nettype none

`include "masked_sprite_blit_scan_defines.svh"

module msbs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `MSBS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    `MSBS_ASSERT_NXT(a_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a frame")

    `MSBS_ASSERT_NXT(a_load_ready, s_tvalid && s_tready && (msbs_pkg::item_kind_t'(s_tuser) == msbs_pkg::KIND_LOAD), s_tready, "mask load blocked input")

endmodule

bind masked_sprite_blit_scan msbs_checker u_msbs_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for masked_sprite_blit_scan: drives draw and mask-load transfers
// and register writes, predicts every pixel result and compares it on the output stream.
// Depends on msbs_pkg and the masked_sprite_blit_scan top level.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_BYTES     = msbs_pkg::ROW_BYTES_DEF;
    localparam int MAX_SIDE      = msbs_pkg::MAX_SIDE_DEF;
    localparam int MASK_CELLS    = msbs_pkg::MASK_CELLS_DEF;
    localparam int SETTLE_CYCLES = 10;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 25;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic                            cell_value;
        logic [msbs_pkg::CELL_IDX_W-1:0] cell_index;
        logic        [3:0]               mask_rows;
        logic        [3:0]               mask_cols;
        logic signed [7:0]               mask_origin_y;
        logic signed [7:0]               mask_origin_x;
        logic                            draw_masked;
        logic                            flip_extra;
        logic                            flip_frame;
        logic signed [11:0]              pos_y;
        logic signed [11:0]              pos_x;
    } sprite_cmd_t;

    class pixel_tracker;
        logic        [7:0] src_x = 8'd0;
        logic        [7:0] src_y = 8'd0;
        logic        [3:0] width_reg = 4'd8;
        logic        [3:0] height_reg = 4'd8;
        logic signed [7:0] anchor_x = 8'sd0;
        logic signed [7:0] anchor_y = 8'sd0;
        logic signed [7:0] shift_x = 8'sd0;
        logic signed [7:0] shift_y = 8'sd0;
        bit                mask [MASK_CELLS];
        msbs_pkg::pix_t    expected_pixels [$];
        int                mismatches = 0;

        function void set_reg(msbs_pkg::cfg_reg_t idx, logic [7:0] val);
            unique case (idx)
                msbs_pkg::REG_FRAME_SRC_X:  src_x = val;
                msbs_pkg::REG_FRAME_SRC_Y:  src_y = val;
                msbs_pkg::REG_FRAME_WIDTH:  width_reg = val[3:0];
                msbs_pkg::REG_FRAME_HEIGHT: height_reg = val[3:0];
                msbs_pkg::REG_ANCHOR_X:     anchor_x = val;
                msbs_pkg::REG_ANCHOR_Y:     anchor_y = val;
                msbs_pkg::REG_SHIFT_X:      shift_x = val;
                msbs_pkg::REG_SHIFT_Y:      shift_y = val;
            endcase
        endfunction

        function void note_item(msbs_pkg::item_kind_t kind, sprite_cmd_t c);
            int w, h, eff_ax, rel_x0, rel_y0, mx, my, ci, slx, n;
            int px, py, mox, moy, mcols, mrows, sx, sy;
            bit flip, sel;
            msbs_pkg::pix_t p;
            if (kind == msbs_pkg::KIND_LOAD)
            begin
                if (c.cell_index < MASK_CELLS)
                    mask[c.cell_index] = c.cell_value;
                return;
            end
            w = (width_reg > MAX_SIDE) ? MAX_SIDE : int'(width_reg);
            h = (height_reg > MAX_SIDE) ? MAX_SIDE : int'(height_reg);
            if (w == 0 || h == 0)
                return;
            px = int'(c.pos_x);
            py = int'(c.pos_y);
            mox = int'(c.mask_origin_x);
            moy = int'(c.mask_origin_y);
            mcols = int'(c.mask_cols);
            mrows = int'(c.mask_rows);
            sx = int'(src_x);
            sy = int'(src_y);
            flip = c.flip_frame ^ c.flip_extra;
            eff_ax = int'(anchor_x);
            if (flip)
                eff_ax = w - eff_ax;
            rel_x0 = int'(shift_x);
            rel_x0 = rel_x0 - eff_ax;
            rel_y0 = int'(shift_y);
            rel_y0 = rel_y0 - int'(anchor_y);
            n = 0;
            for (int ly = 0; ly < h; ly++)
            begin
                my = rel_y0 + ly - moy;
                for (int lx = 0; lx < w; lx++)
                begin
                    mx = rel_x0 + lx - mox;
                    sel = 1'b0;
                    if (mx >= 0 && my >= 0 && mx < mcols && my < mrows)
                    begin
                        ci = my * mcols + mx;
                        if (ci < MASK_CELLS)
                            sel = mask[ci];
                    end
                    slx = flip ? w - 1 - lx : lx;
                    p.dest_x = 13'(px + rel_x0 + lx);
                    p.dest_y = 13'(py + rel_y0 + ly);
                    p.source_offset = 18'((sy + ly) * ROW_BYTES + (sx + slx) * 4);
                    p.write_pixel = (sel == c.draw_masked);
                    p.last = (n + 1 == w * h);
                    expected_pixels.push_back(p);
                    n++;
                end
            end
        endfunction

        function void check_pixel(msbs_pkg::pix_t got);
            msbs_pkg::pix_t want;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: x %0d y %0d off %0d wr %0b last %0b",
                             got.dest_x, got.dest_y, got.source_offset,
                             got.write_pixel, got.last);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
                got.source_offset !== want.source_offset ||
                got.write_pixel !== want.write_pixel || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("pixel mismatch: expected x %0d y %0d off %0d wr %0b last %0b",
                             want.dest_x, want.dest_y, want.source_offset,
                             want.write_pixel, want.last);
                    $display("                got      x %0d y %0d off %0d wr %0b last %0b",
                             got.dest_x, got.dest_y, got.source_offset,
                             got.write_pixel, got.last);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = HOLD_CYCLES;
    bit hold_go = 1'b0;

    pixel_tracker tracker = new;

    masked_sprite_blit_scan u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // once released, hold off the output until hold_left runs out, then stall at random
    always @(negedge clk)
    begin
        if (hold_go && hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        msbs_pkg::pix_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dest_x = m_tdata[12:0];
            got.dest_y = m_tdata[25:13];
            got.source_offset = m_tdata[43:26];
            got.write_pixel = m_tuser;
            got.last = m_tlast;
            tracker.check_pixel(got);
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    function automatic sprite_cmd_t make_draw(int px, int py, bit ff, bit fe, bit dm,
                                              int mox, int moy, int mc, int mr);
        sprite_cmd_t c;
        c = '0;
        c.pos_x = 12'(px);
        c.pos_y = 12'(py);
        c.flip_frame = ff;
        c.flip_extra = fe;
        c.draw_masked = dm;
        c.mask_origin_x = 8'(mox);
        c.mask_origin_y = 8'(moy);
        c.mask_cols = 4'(mc);
        c.mask_rows = 4'(mr);
        return c;
    endfunction

    function automatic sprite_cmd_t make_load(int idx, bit val);
        sprite_cmd_t c;
        c = '0;
        c.cell_index = idx[msbs_pkg::CELL_IDX_W-1:0];
        c.cell_value = val;
        return c;
    endfunction

    function automatic logic signed [7:0] clamp8(int v);
        if (v > 127)
            return 8'sd127;
        if (v < -128)
            return -8'sd128;
        return 8'(v);
    endfunction

    task automatic send_item(msbs_pkg::item_kind_t kind, sprite_cmd_t c);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'b0, c};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_item(kind, c);
    endtask

    task automatic send_random();
        logic [63:0] r;
        sprite_cmd_t c;
        msbs_pkg::item_kind_t kind;
        int base_x, base_y;
        r = {$urandom, $urandom};
        c = sprite_cmd_t'(r[57:0]);
        kind = ($urandom_range(99) < 30) ? msbs_pkg::KIND_LOAD : msbs_pkg::KIND_DRAW;
        // mostly aim the mask at the frame so selection actually varies
        if (kind == msbs_pkg::KIND_DRAW && $urandom_range(99) < 85)
        begin
            base_x = int'(tracker.shift_x);
            base_x = base_x - int'(tracker.anchor_x);
            base_y = int'(tracker.shift_y);
            base_y = base_y - int'(tracker.anchor_y);
            c.mask_cols = 4'($urandom_range(1, MAX_SIDE));
            c.mask_rows = 4'($urandom_range(1, MAX_SIDE));
            c.mask_origin_x = clamp8(base_x + int'($urandom_range(12)) - 8);
            c.mask_origin_y = clamp8(base_y + int'($urandom_range(12)) - 8);
        end
        send_item(kind, c);
    endtask

    task automatic write_reg(msbs_pkg::cfg_reg_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [7:0] fsx, logic [7:0] fsy, logic [3:0] fw,
                                  logic [3:0] fh, logic [7:0] ax, logic [7:0] ay,
                                  logic [7:0] dx, logic [7:0] dy);
        write_reg(msbs_pkg::REG_FRAME_SRC_X, fsx);
        write_reg(msbs_pkg::REG_FRAME_SRC_Y, fsy);
        write_reg(msbs_pkg::REG_FRAME_WIDTH, {4'($urandom_range(15)), fw});
        write_reg(msbs_pkg::REG_FRAME_HEIGHT, {4'($urandom_range(15)), fh});
        write_reg(msbs_pkg::REG_ANCHOR_X, ax);
        write_reg(msbs_pkg::REG_ANCHOR_Y, ay);
        write_reg(msbs_pkg::REG_SHIFT_X, dx);
        write_reg(msbs_pkg::REG_SHIFT_Y, dy);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 0, 0, 0, 8, 8));
        send_item(msbs_pkg::KIND_LOAD, make_load(0, 1));
        send_item(msbs_pkg::KIND_LOAD, make_load(63, 1));
        send_item(msbs_pkg::KIND_LOAD, make_load(9, 1));
        send_item(msbs_pkg::KIND_LOAD, make_load(18, 1));
        send_item(msbs_pkg::KIND_DRAW, make_draw(2047, -2048, 0, 0, 1, 0, 0, 8, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(-2048, 2047, 1, 0, 1, 0, 0, 8, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(5, -5, 1, 1, 1, 0, 0, 8, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 1, 0, -3, 2, 4, 3));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 1, 0, 0, 0, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 1, 0, 0, 15, 15));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 1, -128, 127, 8, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 1, 0, 1, 127, -128, 8, 8));
        send_item(msbs_pkg::KIND_LOAD, make_load(0, 0));
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 1, 0, 0, 8, 8));
        drain();
        apply_settings(8'd255, 8'd255, 4'd0, 4'd8, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(msbs_pkg::KIND_DRAW, make_draw(1, 1, 0, 0, 1, 0, 0, 8, 8));
        drain();
        apply_settings(8'd255, 8'd255, 4'd15, 4'd9, 8'd127, -8'd128, -8'd128, 8'd127);
        send_item(msbs_pkg::KIND_DRAW, make_draw(-7, 9, 1, 0, 1, -1, 0, 8, 8));
        send_item(msbs_pkg::KIND_DRAW, make_draw(7, -9, 0, 0, 0, 0, 0, 8, 8));
        drain();
        apply_settings(8'd0, 8'd0, 4'd3, 4'd0, 8'd2, 8'd1, 8'd0, 8'd0);
        send_item(msbs_pkg::KIND_DRAW, make_draw(0, 0, 0, 0, 1, 0, 0, 8, 8));

        for (int k = 0; k < 4; k++)
        begin
            drain();
            unique case (k)
                1: apply_settings(8'd255, 8'd255, 4'd8, 4'd8,
                                  8'd127, -8'd128, -8'd128, 8'd127);
                3: apply_settings(8'd0, 8'd0, 4'd1, 4'd1,
                                  -8'd128, 8'd127, 8'd127, -8'd128);
                default: apply_settings(8'($urandom), 8'($urandom),
                                        4'($urandom_range(1, MAX_SIDE)),
                                        4'($urandom_range(1, MAX_SIDE)),
                                        8'($urandom_range(8)), 8'($urandom_range(8)),
                                        8'(int'($urandom_range(16)) - 8),
                                        8'(int'($urandom_range(16)) - 8));
            endcase
            @(posedge clk);
            idle_pct = (k == 1 || k == 3) ? ((k == 1) ? 49 : 26) : 0;
            stall_pct = (k == 2 || k == 3) ? ((k == 2) ? 49 : 26) : 0;
            if (k == 0)
                hold_go = 1'b1;
            repeat (PHASE_ITEMS) send_random();
        end
        drain();

        if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ----- masked_sprite_blit_scan.f -----
+incdir+design
design/msbs_pkg.sv
design/msbs_ram.sv
design/msbs_mask.sv
design/msbs_scan.sv
design/masked_sprite_blit_scan.sv
design/msbs_checker.sv
bench/testbench.sv
